// ----- design/tsbb_pkg.sv -----
// ----------------------------------------------------------------------------
// tsbb_pkg: shared types and constants
// Kinds, register indexes, controller states and command/status structs.
// ----------------------------------------------------------------------------
`default_nettype none
package tsbb_pkg;

    localparam int unsigned NumRegs = 6;

    localparam logic [2:0] KIND_NONE    = 3'd0;
    localparam logic [2:0] KIND_BOX     = 3'd1;
    localparam logic [2:0] KIND_POLYGON = 3'd2;
    localparam logic [2:0] KIND_CIRCLE  = 3'd3;
    localparam logic [2:0] KIND_CAPSULE = 3'd4;

    localparam logic [2:0] REG_COL0_X   = 3'd0;
    localparam logic [2:0] REG_COL0_Y   = 3'd1;
    localparam logic [2:0] REG_COL1_X   = 3'd2;
    localparam logic [2:0] REG_COL1_Y   = 3'd3;
    localparam logic [2:0] REG_OFFSET_X = 3'd4;
    localparam logic [2:0] REG_OFFSET_Y = 3'd5;

    localparam logic signed [31:0] QOne = 32'sd65536;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ0,
        ST_SQ1,
        ST_SQRT,
        ST_PT_MUL,
        ST_PT_FOLD,
        ST_C1_MUL,
        ST_C1_FOLD,
        ST_C2_MUL,
        ST_C2_FOLD,
        ST_OUT
    } state_t;

    // Source select for the point fed to the transform multipliers.
    typedef enum logic [1:0] {
        SEL_PXY,
        SEL_FX_PY,
        SEL_PX_FY
    } psel_t;

    typedef struct packed {
        logic  capture;     // latch the accepted request
        logic  sq_col0;     // square column 0 lengths
        logic  sq_col1;     // square column 1 lengths
        logic  sqrt_start;
        logic  mul;         // multiply selected point
        psel_t psel;
        logic  fold;        // fold transformed point into running box
        logic  widen;       // widen by scaled radius
        logic  start_shape; // record first corner and clear fold
        logic  end_shape;   // load result and reset shape
        logic  zero_out;    // result is an all-zero box
    } cmd_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       last;
        logic       started;
        logic       sqrt_done;
    } sts_t;

endpackage
`default_nettype wire

// ----- design/tsbb_if.sv -----
// ----------------------------------------------------------------------------
// tsbb_if: valid/ready channel interfaces
// Point channel, box channel and configuration write channel.
// ----------------------------------------------------------------------------
`default_nettype none
interface tsbb_point_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [31:0] point_x;
    logic [31:0] point_y;
    logic [30:0] radius;
    logic        last;
    modport source (output valid, kind, point_x, point_y, radius, last, input ready);
    modport sink (input valid, kind, point_x, point_y, radius, last, output ready);
endinterface

interface tsbb_box_if;
    logic        valid;
    logic        ready;
    logic [31:0] box_min_x;
    logic [31:0] box_min_y;
    logic [31:0] box_max_x;
    logic [31:0] box_max_y;
    modport source (output valid, box_min_x, box_min_y, box_max_x, box_max_y, input ready);
    modport sink (input valid, box_min_x, box_min_y, box_max_x, box_max_y, output ready);
endinterface

interface tsbb_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- design/transformed_shape_bounding_box.sv -----
// ----------------------------------------------------------------------------
// transformed_shape_bounding_box: bounding box of an affine-transformed shape
// Top level joining the sequencer and the datapath.
// ----------------------------------------------------------------------------
// Points arrive on the point channel, one request per vertex, corner, center
// or endpoint, tagged with the shape kind; the request with last set closes
// the shape and one box leaves on the box channel. The user must write the
// six matrix and offset registers on the cfg channel only while the block
// is idle; the block itself does not enforce it. A continuing point steps
// through capture, check, multiply and fold; a box point after the first
// adds a multiply and a fold for each of its two extra corners. The first
// point of a circle, capsule, box or polygon also runs the shared bit-serial
// square root twice, once per column length, each run a start step and then
// its iterations. Closing a shape adds a step to load the output register.
// Reset restores the identity transform and clears any shape in progress.
// When the receiver stalls, the finished box holds in the output register;
// the block keeps working up to the next closing request and then waits.
// ----------------------------------------------------------------------------
`default_nettype none
module transformed_shape_bounding_box
    import tsbb_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    tsbb_point_if.sink   points,
    tsbb_box_if.source   boxes,
    tsbb_cfg_if.sink     cfg
);
    cmd_t cmd;
    sts_t sts;

    assign cfg.ready = 1'b1;

    tsbb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (points.valid),
        .in_ready  (points.ready),
        .out_valid (boxes.valid),
        .out_ready (boxes.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    tsbb_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_we    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .in_kind   (points.kind),
        .in_x      (points.point_x),
        .in_y      (points.point_y),
        .in_radius (points.radius),
        .in_last   (points.last),
        .res_min_x (boxes.box_min_x),
        .res_min_y (boxes.box_min_y),
        .res_max_x (boxes.box_max_x),
        .res_max_y (boxes.box_max_y)
    );
endmodule
`default_nettype wire

// ----- design/tsbb_sqrt.sv -----
// ----------------------------------------------------------------------------
// tsbb_sqrt: iterative integer square root
// Floor square root of a 64-bit value, one result bit per cycle from two
// operand bits; done flags the cycle in which root is valid.
// ----------------------------------------------------------------------------
`default_nettype none
module tsbb_sqrt
    import tsbb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] value,
    output logic             done,
    output logic [31:0]      root
);
    logic [63:0] rem_reg, rem_next;
    logic [31:0] res_reg, res_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [65:0] trial;
    logic [65:0] rem_sh;

    always_comb
    begin
        rem_next  = rem_reg;
        res_next  = res_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        // Bring in the next two bits of the operand, shifted left each step.
        rem_sh = {rem_reg, 2'b00} | {64'd0, value[7'd63 - {cnt_reg[4:0], 1'b0} -: 2]};
        trial  = {32'd0, res_reg, 2'b01};
        if (start)
        begin
            rem_next  = '0;
            res_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= trial)
            begin
                rem_next = 64'(rem_sh - trial);
                res_next = {res_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[63:0];
                res_next = {res_reg[30:0], 1'b0};
            end
            cnt_next = 6'(cnt_reg + 6'd1);
            if (cnt_reg == 6'd31)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        res_reg <= res_next;
    end

    assign done = busy_reg && (cnt_reg == 6'd31);
    assign root = {res_reg[30:0], (rem_sh >= trial)};
endmodule
`default_nettype wire

// ----- design/tsbb_datapath.sv -----
// ----------------------------------------------------------------------------
// tsbb_datapath: transform, widen and fold
// Holds the registers, the captured request, the running box and the result.
// ----------------------------------------------------------------------------
`default_nettype none
module tsbb_datapath
    import tsbb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cmd_t        cmd,
    output sts_t             sts,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic [2:0]  in_kind,
    input  wire logic [31:0] in_x,
    input  wire logic [31:0] in_y,
    input  wire logic [30:0] in_radius,
    input  wire logic        in_last,
    output logic [31:0]      res_min_x,
    output logic [31:0]      res_min_y,
    output logic [31:0]      res_max_x,
    output logic [31:0]      res_max_y
);
    logic signed [31:0] mreg_reg [NumRegs];
    logic [2:0]  kind_reg;
    logic signed [31:0] px_reg, py_reg, fx_reg, fy_reg;
    logic [30:0] rad_reg;
    logic        last_reg;
    logic        started_reg;
    logic        empty_reg;
    logic [31:0] scale_reg;
    logic signed [31:0] rmin_x_reg, rmin_y_reg, rmax_x_reg, rmax_y_reg;
    logic signed [63:0] p0_reg, p1_reg, p2_reg, p3_reg;
    logic [63:0] sqa_reg, sqb_reg;
    logic [31:0] len0_reg;
    logic [47:0] rr_reg;
    logic [31:0] out_min_x_reg, out_min_y_reg, out_max_x_reg, out_max_y_reg;
    logic        sqrt_done;
    logic [31:0] root;
    logic [63:0] sq_sum;
    logic signed [31:0] ax, ay;
    logic signed [49:0] tx_w, ty_w;
    logic signed [49:0] rr_s;
    logic signed [31:0] tx, ty, lx, ly, hx, hy;
    logic [31:0] new_scale;

    function automatic logic signed [31:0] sat50(input logic signed [49:0] v);
        if (v > 50'sh0007FFFFFFF)
        begin
            return 32'sh7FFFFFFF;
        end
        if (v < -50'sh00080000000)
        begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // Sum of two Q32.32 products, floored to Q16.16 exactly.
    function automatic logic signed [49:0] sum_q(input logic signed [63:0] a,
                                                 input logic signed [63:0] b,
                                                 input logic signed [31:0] off);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        return 50'(s >>> 16) + 50'(off);
    endfunction

    always_comb
    begin
        unique case (cmd.psel)
            SEL_FX_PY: begin ax = fx_reg; ay = py_reg; end
            SEL_PX_FY: begin ax = px_reg; ay = fy_reg; end
            default:   begin ax = px_reg; ay = py_reg; end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            p0_reg <= mreg_reg[REG_COL0_X] * ax;
            p1_reg <= mreg_reg[REG_COL1_X] * ay;
            p2_reg <= mreg_reg[REG_COL0_Y] * ax;
            p3_reg <= mreg_reg[REG_COL1_Y] * ay;
        end
        if (cmd.sq_col0)
        begin
            sqa_reg <= 64'(mreg_reg[REG_COL0_X] * mreg_reg[REG_COL0_X]);
            sqb_reg <= 64'(mreg_reg[REG_COL0_Y] * mreg_reg[REG_COL0_Y]);
        end
        if (cmd.sq_col1)
        begin
            sqa_reg <= 64'(mreg_reg[REG_COL1_X] * mreg_reg[REG_COL1_X]);
            sqb_reg <= 64'(mreg_reg[REG_COL1_Y] * mreg_reg[REG_COL1_Y]);
        end
        if (cmd.capture)
        begin
            kind_reg <= in_kind;
            px_reg   <= in_x;
            py_reg   <= in_y;
            rad_reg  <= in_radius;
            last_reg <= in_last;
        end
        if (cmd.start_shape)
        begin
            fx_reg <= px_reg;
            fy_reg <= py_reg;
        end
        // The first root completes in the same cycle as the second squaring.
        if (cmd.sq_col1)
        begin
            len0_reg <= root;
        end
        // Radius times scale, scaled back to Q16.16.
        rr_reg <= 48'((64'(rad_reg) * 64'(scale_reg)) >> 16);
        if (cmd.end_shape)
        begin
            out_min_x_reg <= cmd.zero_out ? 32'd0 : rmin_x_reg;
            out_min_y_reg <= cmd.zero_out ? 32'd0 : rmin_y_reg;
            out_max_x_reg <= cmd.zero_out ? 32'd0 : rmax_x_reg;
            out_max_y_reg <= cmd.zero_out ? 32'd0 : rmax_y_reg;
        end
    end

    assign sq_sum = 64'(sqa_reg + sqb_reg);

    tsbb_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.sqrt_start),
        .value (sq_sum),
        .done  (sqrt_done),
        .root  (root)
    );

    assign new_scale = (len0_reg > root) ? len0_reg : root;
    assign rr_s      = $signed({2'b00, rr_reg});

    always_comb
    begin
        tx_w = sum_q(p0_reg, p1_reg, mreg_reg[REG_OFFSET_X]);
        ty_w = sum_q(p2_reg, p3_reg, mreg_reg[REG_OFFSET_Y]);
        tx = sat50(tx_w);
        ty = sat50(ty_w);
        if (cmd.widen)
        begin
            lx = sat50(50'(tx) - rr_s);
            ly = sat50(50'(ty) - rr_s);
            hx = sat50(50'(tx) + rr_s);
            hy = sat50(50'(ty) + rr_s);
        end
        else
        begin
            lx = tx; ly = ty; hx = tx; hy = ty;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mreg_reg[REG_COL0_X]   <= QOne;
            mreg_reg[REG_COL0_Y]   <= '0;
            mreg_reg[REG_COL1_X]   <= '0;
            mreg_reg[REG_COL1_Y]   <= QOne;
            mreg_reg[REG_OFFSET_X] <= '0;
            mreg_reg[REG_OFFSET_Y] <= '0;
            started_reg <= 1'b0;
            empty_reg   <= 1'b1;
            scale_reg   <= 32'(QOne);
            rmin_x_reg  <= '0;
            rmin_y_reg  <= '0;
            rmax_x_reg  <= '0;
            rmax_y_reg  <= '0;
        end
        else
        begin
            if (cfg_we && (32'(cfg_index) < NumRegs))
            begin
                mreg_reg[cfg_index] <= cfg_data;
            end
            // The second root finishes after the first; keep the larger.
            if (sqrt_done && !cmd.sq_col1)
            begin
                scale_reg <= new_scale;
            end
            if (cmd.start_shape)
            begin
                started_reg <= 1'b1;
                empty_reg   <= 1'b1;
            end
            if (cmd.fold)
            begin
                empty_reg <= 1'b0;
                if (empty_reg || lx < rmin_x_reg) rmin_x_reg <= lx;
                if (empty_reg || ly < rmin_y_reg) rmin_y_reg <= ly;
                if (empty_reg || hx > rmax_x_reg) rmax_x_reg <= hx;
                if (empty_reg || hy > rmax_y_reg) rmax_y_reg <= hy;
            end
            if (cmd.end_shape)
            begin
                started_reg <= 1'b0;
                empty_reg   <= 1'b1;
            end
        end
    end

    assign sts.kind      = kind_reg;
    assign sts.last      = last_reg;
    assign sts.started   = started_reg;
    assign sts.sqrt_done = sqrt_done;
    assign res_min_x = out_min_x_reg;
    assign res_min_y = out_min_y_reg;
    assign res_max_x = out_max_x_reg;
    assign res_max_y = out_max_y_reg;
endmodule
`default_nettype wire

// ----- design/tsbb_ctrl.sv -----
// ----------------------------------------------------------------------------
// tsbb_ctrl: request sequencer
// Steps each accepted point through scale, transform and fold cycles.
// ----------------------------------------------------------------------------
`default_nettype none
module tsbb_ctrl
    import tsbb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);
    state_t state_reg, state_next;
    logic   sqrt_n_reg, sqrt_n_next;
    logic   valid_reg, valid_next;
    logic   real_kind;

    assign real_kind = (sts.kind == KIND_BOX) || (sts.kind == KIND_POLYGON)
                    || (sts.kind == KIND_CIRCLE) || (sts.kind == KIND_CAPSULE);

    always_comb
    begin
        state_next  = state_reg;
        sqrt_n_next = sqrt_n_reg;
        valid_next  = valid_reg;
        cmd         = '0;
        cmd.psel    = SEL_PXY;
        in_ready    = 1'b0;
        if (valid_reg && out_ready)
        begin
            valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SQ0;
                end
            end
            ST_SQ0:
            begin
                if (!real_kind)
                begin
                    state_next = sts.last ? ST_OUT : ST_IDLE;
                end
                else if (!sts.started)
                begin
                    cmd.sq_col0 = 1'b1;
                    cmd.start_shape = 1'b1;
                    sqrt_n_next = 1'b0;
                    state_next  = ST_SQ1;
                end
                else
                begin
                    state_next = ST_PT_MUL;
                end
            end
            ST_SQ1:
            begin
                cmd.sqrt_start = 1'b1;
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                if (sts.sqrt_done)
                begin
                    if (!sqrt_n_reg)
                    begin
                        cmd.sq_col1 = 1'b1;
                        sqrt_n_next = 1'b1;
                        state_next  = ST_SQ1;
                    end
                    else
                    begin
                        state_next = ST_PT_MUL;
                    end
                end
            end
            ST_PT_MUL:
            begin
                cmd.mul = 1'b1;
                state_next = ST_PT_FOLD;
            end
            ST_PT_FOLD:
            begin
                cmd.fold  = 1'b1;
                cmd.widen = (sts.kind == KIND_CIRCLE) || (sts.kind == KIND_CAPSULE);
                if ((sts.kind == KIND_BOX) && sqrt_n_reg == 1'b0 && sts.started)
                begin
                    state_next = ST_C1_MUL;
                end
                else
                begin
                    state_next = sts.last ? ST_OUT : ST_IDLE;
                end
            end
            ST_C1_MUL:
            begin
                cmd.mul  = 1'b1;
                cmd.psel = SEL_FX_PY;
                state_next = ST_C1_FOLD;
            end
            ST_C1_FOLD:
            begin
                cmd.fold = 1'b1;
                state_next = ST_C2_MUL;
            end
            ST_C2_MUL:
            begin
                cmd.mul  = 1'b1;
                cmd.psel = SEL_PX_FY;
                state_next = ST_C2_FOLD;
            end
            ST_C2_FOLD:
            begin
                cmd.fold = 1'b1;
                state_next = sts.last ? ST_OUT : ST_IDLE;
            end
            ST_OUT:
            begin
                if (!valid_reg || out_ready)
                begin
                    cmd.end_shape = 1'b1;
                    cmd.zero_out  = !real_kind;
                    valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        // A shape that began on this request skips the extra box corners.
        if (state_reg == ST_SQ0 && real_kind && sts.started)
        begin
            sqrt_n_next = 1'b0;
        end
        else if (state_reg == ST_SQ0 && real_kind)
        begin
            sqrt_n_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            sqrt_n_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sqrt_n_reg <= (state_reg == ST_SQRT && sts.sqrt_done && sqrt_n_reg)
                          ? 1'b1 : sqrt_n_next;
            valid_reg  <= valid_next;
        end
    end

    assign out_valid = valid_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == ST_IDLE)
        else $error("ready outside idle");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.end_shape |=> valid_reg)
        else $error("result not presented");
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !out_ready) |=> valid_reg)
        else $error("result dropped while stalled");
`endif
endmodule
`default_nettype wire

// ----- test/tsbb_tb_if.sv -----
// ----------------------------------------------------------------------------
// tsbb_tb_if: testbench view of the channels
// The block's own interface file is compiled with the design; nothing extra
// is needed here beyond small record types for expected boxes and queued points.
// ----------------------------------------------------------------------------
package tsbb_tb_pkg;

    typedef struct packed {
        logic [31:0] min_x;
        logic [31:0] min_y;
        logic [31:0] max_x;
        logic [31:0] max_y;
    } box_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] px;
        logic [31:0] py;
        logic [30:0] radius;
        logic        last;
    } point_t;

endpackage

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench for transformed_shape_bounding_box
// Streams shapes of every kind under several transforms, predicts each
// bounding box in the testbench and compares it with the box channel.
// ----------------------------------------------------------------------------
module tb_top;
    import tsbb_pkg::*;
    import tsbb_tb_pkg::*;

    localparam int WatchdogLimit = 20000;

    logic clk;
    logic rst_n;

    tsbb_point_if points ();
    tsbb_box_if   boxes ();
    tsbb_cfg_if   cfg ();

    transformed_shape_bounding_box i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .points (points.sink),
        .boxes  (boxes.source),
        .cfg    (cfg.sink)
    );

    // Transform state as the block should hold it.
    logic signed [31:0] xf_reg [6];
    logic signed [31:0] acc_min_x, acc_min_y, acc_max_x, acc_max_y;
    logic signed [31:0] corner_x, corner_y;
    logic               in_shape;
    logic               acc_empty;
    logic [31:0]        scale_q;

    point_t pending_points [$];
    box_t   expected_boxes [$];

    int  send_idle_pct;
    int  recv_stall_pct;
    bit  recv_hold;
    int  hold_cycles;
    bit  failed;
    int  quiet_cycles;
    bit  stim_done;

    always #5 clk = ~clk;

    function automatic logic signed [31:0] clamp32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)
            return 32'sh7fffffff;
        if (v < -66'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // Arithmetic shift of the exact Q32.32 sum gives the floor narrowing.
    function automatic void map_point(input logic signed [31:0] px,
                                      input logic signed [31:0] py,
                                      output logic signed [31:0] tx,
                                      output logic signed [31:0] ty);
        logic signed [65:0] sx, sy;
        sx = 66'(xf_reg[REG_COL0_X] * 64'(px)) + 66'(64'(xf_reg[REG_COL1_X]) * py);
        sy = 66'(xf_reg[REG_COL0_Y] * 64'(px)) + 66'(64'(xf_reg[REG_COL1_Y]) * py);
        sx = (sx >>> 16) + 66'(xf_reg[REG_OFFSET_X]);
        sy = (sy >>> 16) + 66'(xf_reg[REG_OFFSET_Y]);
        tx = clamp32(sx);
        ty = clamp32(sy);
    endfunction

    function automatic logic [31:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res[31:0];
    endfunction

    function automatic logic [31:0] column_length(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic [63:0] sa, sb;
        sa = 64'(a * 64'(a));
        sb = 64'(b * 64'(b));
        return floor_sqrt(sa + sb);
    endfunction

    function automatic void grow_box(input logic signed [31:0] lx, ly, hx, hy);
        if (acc_empty)
        begin
            acc_min_x = lx; acc_min_y = ly; acc_max_x = hx; acc_max_y = hy;
            acc_empty = 0;
        end
        else
        begin
            if (lx < acc_min_x) acc_min_x = lx;
            if (ly < acc_min_y) acc_min_y = ly;
            if (hx > acc_max_x) acc_max_x = hx;
            if (hy > acc_max_y) acc_max_y = hy;
        end
    endfunction

    function automatic void grow_by_point(input logic signed [31:0] px, py);
        logic signed [31:0] tx, ty;
        map_point(px, py, tx, ty);
        grow_box(tx, ty, tx, ty);
    endfunction

    function automatic void predict_box(input point_t p);
        logic [31:0]        l0, l1;
        logic signed [31:0] tx, ty;
        logic signed [65:0] rr;
        box_t               b;
        if (p.kind == KIND_NONE || p.kind > KIND_CAPSULE)
        begin
            if (!p.last)
                return;
            in_shape = 0;
            acc_empty = 1;
            expected_boxes.push_back('0);
            return;
        end
        if (!in_shape)
        begin
            l0 = column_length(xf_reg[REG_COL0_X], xf_reg[REG_COL0_Y]);
            l1 = column_length(xf_reg[REG_COL1_X], xf_reg[REG_COL1_Y]);
            scale_q = (l0 > l1) ? l0 : l1;
            corner_x = p.px;
            corner_y = p.py;
            acc_empty = 1;
            in_shape = 1;
            grow_by_point(p.px, p.py);
        end
        else if (p.kind == KIND_BOX)
        begin
            grow_by_point(p.px, p.py);
            grow_by_point(corner_x, p.py);
            grow_by_point(p.px, corner_y);
        end
        else if (p.kind == KIND_POLYGON)
            grow_by_point(p.px, p.py);
        if (p.kind == KIND_CIRCLE || p.kind == KIND_CAPSULE)
        begin
            // A fresh circle point was folded unwidened above; widening a
            // superset of that point leaves the same result.
            rr = 66'((64'(p.radius) * 64'(scale_q)) >> 16);
            map_point(p.px, p.py, tx, ty);
            grow_box(clamp32(66'(tx) - rr), clamp32(66'(ty) - rr),
                     clamp32(66'(tx) + rr), clamp32(66'(ty) + rr));
        end
        if (!p.last)
            return;
        in_shape = 0;
        acc_empty = 1;
        b.min_x = acc_min_x; b.min_y = acc_min_y;
        b.max_x = acc_max_x; b.max_y = acc_max_y;
        expected_boxes.push_back(b);
    endfunction

    // Driver: point requests come from the pending queue.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            points.valid <= 0;
            points.kind <= '0;
            points.point_x <= '0;
            points.point_y <= '0;
            points.radius <= '0;
            points.last <= 0;
        end
        else
        begin
            if (!points.valid || points.ready)
            begin
                if (pending_points.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    point_t p;
                    p = pending_points.pop_front();
                    points.valid <= 1;
                    points.kind <= p.kind;
                    points.point_x <= p.px;
                    points.point_y <= p.py;
                    points.radius <= p.radius;
                    points.last <= p.last;
                end
                else
                    points.valid <= 0;
            end
        end
    end

    // Prediction runs at the accepting edge so it sees the current transform.
    always @(posedge clk)
    begin
        if (rst_n && points.valid && points.ready)
            predict_box({points.kind, points.point_x, points.point_y,
                         points.radius, points.last});
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            boxes.ready <= 0;
        else
            boxes.ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor.
    always @(posedge clk)
    begin
        if (rst_n && boxes.valid && boxes.ready)
        begin
            box_t e;
            if (expected_boxes.size() == 0)
            begin
                $error("box with nothing expected");
                failed = 1;
            end
            else
            begin
                e = expected_boxes.pop_front();
                if (boxes.box_min_x !== e.min_x)
                begin
                    $error("box_min_x exp %h got %h", e.min_x, boxes.box_min_x);
                    failed = 1;
                end
                if (boxes.box_min_y !== e.min_y)
                begin
                    $error("box_min_y exp %h got %h", e.min_y, boxes.box_min_y);
                    failed = 1;
                end
                if (boxes.box_max_x !== e.max_x)
                begin
                    $error("box_max_x exp %h got %h", e.max_x, boxes.box_max_x);
                    failed = 1;
                end
                if (boxes.box_max_y !== e.max_y)
                begin
                    $error("box_max_y exp %h got %h", e.max_y, boxes.box_max_y);
                    failed = 1;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted transfer on any channel.
    always @(posedge clk)
    begin
        if ((points.valid && points.ready) || (boxes.valid && boxes.ready)
            || (cfg.valid && cfg.ready) || stim_done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchdogLimit)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Each write lowers valid on the cfg channel again before it returns.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg.valid <= 1;
        cfg.index <= idx;
        cfg.data <= val;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        xf_reg[idx] = val;
        cfg.valid <= 0;
        @(posedge clk);
    endtask

    task automatic drain_boxes();
        while (pending_points.size() > 0 || points.valid || expected_boxes.size() > 0)
            @(posedge clk);
        repeat (200)
            @(posedge clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'($urandom_range(131072) - 65536);
            default: return $urandom();
        endcase
    endfunction

    function automatic void queue_point(input logic [2:0] k, input logic [31:0] x, y,
                                        input logic [30:0] r, input logic l);
        point_t p;
        p.kind = k; p.px = x; p.py = y; p.radius = r; p.last = l;
        pending_points.push_back(p);
    endfunction

    // One shape with random content, at times with stray kinds; returns its item count.
    function automatic int queue_shape();
        logic [2:0] k;
        int         n;
        k = 3'($urandom_range(4));
        if ($urandom_range(19) == 0)
            k = 3'($urandom_range(7));
        case (k)
            KIND_BOX: n = ($urandom_range(9) == 0) ? $urandom_range(1, 4) : 2;
            KIND_CAPSULE: n = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : 2;
            KIND_CIRCLE: n = ($urandom_range(9) == 0) ? 2 : 1;
            KIND_POLYGON: n = $urandom_range(1, 8);
            default: n = 1;
        endcase
        for (int i = 0; i < n; i++)
            queue_point(($urandom_range(15) == 0) ? 3'($urandom_range(7)) : k,
                        rand_word(), rand_word(),
                        ($urandom_range(3) == 0) ? 31'($urandom()) :
                            31'($urandom_range(200000)),
                        i == n - 1);
        // Occasional ignored noise or unterminated fragment.
        if ($urandom_range(9) == 0)
            queue_point(KIND_NONE, rand_word(), rand_word(), 31'($urandom()), 1'b0);
        return n;
    endfunction

    task automatic run_random(input int count, input int idle, input int stall);
        int sent;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        sent = 0;
        while (sent < count)
        begin
            sent += queue_shape();
            while (pending_points.size() > 8)
                @(posedge clk);
        end
        drain_boxes();
    endtask

    initial
    begin
        clk = 0;
        rst_n = 0;
        failed = 0;
        stim_done = 0;
        recv_hold = 0;
        quiet_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        cfg.valid = 0;
        cfg.index = '0;
        cfg.data = '0;
        in_shape = 0;
        acc_empty = 1;
        scale_q = 32'd65536;
        acc_min_x = 0; acc_min_y = 0; acc_max_x = 0; acc_max_y = 0;
        corner_x = 0; corner_y = 0;
        xf_reg[REG_COL0_X] = QOne;
        xf_reg[REG_COL0_Y] = 0;
        xf_reg[REG_COL1_X] = 0;
        xf_reg[REG_COL1_Y] = QOne;
        xf_reg[REG_OFFSET_X] = 0;
        xf_reg[REG_OFFSET_Y] = 0;
        repeat (12)
            @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: identity transform, every kind and the corner cases.
        queue_point(KIND_NONE, 1, 2, 3, 1);
        queue_point(KIND_NONE, 5, 5, 5, 0);
        queue_point(KIND_BOX, 32'h80000000, 32'h80000000, 0, 0);
        queue_point(KIND_BOX, 32'h7fffffff, 32'h7fffffff, 0, 1);
        queue_point(KIND_BOX, 32'h00030000, 32'hfffe0000, 0, 1);
        queue_point(KIND_BOX, 0, 0, 0, 0);
        queue_point(KIND_BOX, 32'h10000, 32'h20000, 0, 0);
        queue_point(KIND_BOX, 32'hffff0000, 32'h50000, 0, 1);
        queue_point(KIND_POLYGON, 32'h10000, 0, 0, 0);
        queue_point(KIND_POLYGON, 32'hfff00000, 32'h7fffffff, 0, 0);
        queue_point(KIND_POLYGON, 5, 32'h80000000, 0, 1);
        queue_point(KIND_CIRCLE, 32'h7fff0000, 0, 31'h7fffffff, 1);
        queue_point(KIND_CIRCLE, 0, 0, 31'h10000, 1);
        queue_point(KIND_CAPSULE, 0, 0, 31'h20000, 0);
        queue_point(KIND_CAPSULE, 32'h100000, 32'h100000, 31'h8000, 1);
        queue_point(KIND_POLYGON, 1, 1, 0, 0);
        queue_point(KIND_CIRCLE, 2, 2, 31'h30000, 0);
        queue_point(3'd6, 0, 0, 0, 0);
        queue_point(3'd7, 9, 9, 9, 1);
        queue_point(KIND_POLYGON, 3, 3, 0, 0);
        queue_point(3'd5, 0, 0, 0, 1);
        drain_boxes();

        // Extreme transform.
        write_reg(REG_COL0_X, 32'h7fffffff);
        write_reg(REG_COL0_Y, 32'h80000000);
        write_reg(REG_COL1_X, 32'h80000000);
        write_reg(REG_COL1_Y, 32'h7fffffff);
        write_reg(REG_OFFSET_X, 32'h7fffffff);
        write_reg(REG_OFFSET_Y, 32'h80000000);
        run_random(150, 0, 0);

        // Receiver holds off long while the sender keeps offering.
        recv_hold = 1;
        for (int i = 0; i < 40; i++)
            void'(queue_shape());
        hold_cycles = 0;
        while (hold_cycles < 3000)
        begin
            @(posedge clk);
            hold_cycles++;
        end
        recv_hold = 0;
        drain_boxes();

        for (int ph = 0; ph < 4; ph++)
        begin
            for (int r = 0; r < 6; r++)
                write_reg(3'(r), (r == ph) ? 32'(QOne) : rand_word());
            case (ph)
                0: run_random(330, 0, 0);
                1: run_random(330, 82, 0);
                2: run_random(330, 0, 82);
                default: run_random(330, 28, 28);
            endcase
        end

        stim_done = 1;
        if (!failed && expected_boxes.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
